/* hdl/mclb_pkg.sv */
// ----------------------------------------------------------------------------
// mclb_pkg: shared types and constants of the LED blinker
// Holds the transaction structs, the command codes and the cell interfaces.
// ----------------------------------------------------------------------------
package mclb_pkg;

  // Field widths fixed by the command format.
  localparam int unsigned MODE_W = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned WORD_W = 32;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_SET     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ENABLE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DISABLE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd4;

  // Input transaction.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic              level;
    logic [WORD_W-1:0] period_ms;
    logic [WORD_W-1:0] now_ms;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [WORD_W-1:0] led_pattern;
    logic              pattern_driven;
  } out_item_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic              level;
    logic [WORD_W-1:0] period_ms;
    logic [WORD_W-1:0] now_ms;
  } cell_cmd_t;

  // Tick token passed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] now_ms;
    logic              toggled;
  } token_t;

endpackage

/* hdl/mclb_cell.sv */
// ----------------------------------------------------------------------------
// mclb_cell: state of one LED
// Holds the LED level, blink enable, period and last toggle time, applies
// addressed commands, and evaluates the tick token as it passes.
// ----------------------------------------------------------------------------
module mclb_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mclb_pkg::cell_cmd_t cmd,
  input  mclb_pkg::token_t   tok_in,
  output mclb_pkg::token_t   tok_out,
  output logic               led
);

  logic                        led_r, led_nxt;
  logic                        en_r, en_nxt;
  logic [mclb_pkg::WORD_W-1:0] period_r, period_nxt;
  logic [mclb_pkg::WORD_W-1:0] last_r, last_nxt;
  mclb_pkg::token_t            tok_r, tok_nxt;
  logic                        hit;
  logic                        fire;
  logic [mclb_pkg::WORD_W-1:0] elapsed;

  // This cell is addressed by the broadcast command.
  assign hit = cmd.valid && (cmd.position == mclb_pkg::POS_W'(INDEX));

  // Elapsed time wraps modulo the word size.
  assign elapsed = tok_in.now_ms - last_r;
  assign fire    = tok_in.valid && en_r && (elapsed >= period_r);

  // Next-state logic for commands and the passing token.
  always_comb begin
    led_nxt    = led_r;
    en_nxt     = en_r;
    period_nxt = period_r;
    last_nxt   = last_r;
    if (hit) begin
      case (cmd.mode)
        mclb_pkg::MODE_SET: begin
          en_nxt  = 1'b0;
          led_nxt = cmd.level;
        end
        mclb_pkg::MODE_TOGGLE: begin
          en_nxt  = 1'b0;
          led_nxt = ~led_r;
        end
        mclb_pkg::MODE_ENABLE: begin
          en_nxt     = 1'b1;
          period_nxt = cmd.period_ms;
          last_nxt   = cmd.now_ms;
        end
        mclb_pkg::MODE_DISABLE: begin
          en_nxt  = 1'b0;
          led_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (fire) begin
      led_nxt  = ~led_r;
      last_nxt = tok_in.now_ms;
    end
    tok_nxt         = tok_in;
    tok_nxt.toggled = tok_in.toggled | fire;
  end

  // Control state is reset; period and time are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r       <= 1'b0;
      en_r        <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      led_r       <= led_nxt;
      en_r        <= en_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    period_r      <= period_nxt;
    last_r        <= last_nxt;
    tok_r.now_ms  <= tok_nxt.now_ms;
    tok_r.toggled <= tok_nxt.toggled;
  end

  assign tok_out = tok_r;
  assign led     = led_r;

endmodule

/* hdl/multi_channel_led_blinker_unit.sv */
// ----------------------------------------------------------------------------
// multi_channel_led_blinker_unit: LED driver with per-LED blinking
// A row of LED cells driven by set, toggle, blink and tick commands.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Set, toggle, enable-blink, disable-blink
// and unknown modes pass from acceptance to the ST_CMD state, which registers
// the LED pattern as the result. A tick sends a token down the row of
// LED_COUNT cells, one cell per cycle, each cell checking its own elapsed
// time as the token passes, and the result is registered once the token
// leaves the last cell. A new transaction is taken in the cycle after the
// result is registered, or later while the result is held by a stall.
// ----------------------------------------------------------------------------
module multi_channel_led_blinker_unit #(
  parameter int unsigned LED_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mclb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mclb_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMD  = 3'b010,
    ST_WALK = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        driven_r, driven_nxt;
  logic                        out_valid_r, out_valid_nxt;
  mclb_pkg::out_item_t         out_item_r, out_item_nxt;
  logic                        in_accept;
  logic                        is_tick;
  logic [LED_COUNT-1:0]        led_vec;
  logic [mclb_pkg::WORD_W-1:0] led_word;
  mclb_pkg::cell_cmd_t         cmd;
  mclb_pkg::token_t            tok [LED_COUNT+1];

  // Accept only when idle and the result register is free or draining.
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign is_tick   = (in_item.mode == mclb_pkg::MODE_TICK);

  // Broadcast addressed commands to all cells.
  always_comb begin
    cmd.valid     = in_accept && !is_tick;
    cmd.mode      = in_item.mode;
    cmd.position  = in_item.position;
    cmd.level     = in_item.level;
    cmd.period_ms = in_item.period_ms;
    cmd.now_ms    = in_item.now_ms;
  end

  // Inject the tick token at the head of the row.
  always_comb begin
    tok[0].valid   = in_accept && is_tick;
    tok[0].now_ms  = in_item.now_ms;
    tok[0].toggled = 1'b0;
  end

  // Row of LED cells.
  for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
    mclb_cell #(
      .INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .tok_in (tok[i]),
      .tok_out(tok[i+1]),
      .led    (led_vec[i])
    );
  end

  // Widen the LED vector to the pattern word.
  always_comb begin
    led_word                = '0;
    led_word[LED_COUNT-1:0] = led_vec;
  end

  // Sequencer and result register.
  always_comb begin
    state_nxt     = state_r;
    driven_nxt    = driven_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          driven_nxt = (in_item.mode == mclb_pkg::MODE_SET ||
                        in_item.mode == mclb_pkg::MODE_TOGGLE ||
                        in_item.mode == mclb_pkg::MODE_DISABLE) &&
                       (32'(in_item.position) < LED_COUNT);
          state_nxt  = is_tick ? ST_WALK : ST_CMD;
        end
      end
      ST_CMD: begin
        out_valid_nxt               = 1'b1;
        out_item_nxt.led_pattern    = led_word;
        out_item_nxt.pattern_driven = driven_r;
        state_nxt                   = ST_IDLE;
      end
      ST_WALK: begin
        if (tok[LED_COUNT].valid) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.led_pattern    = led_word;
          out_item_nxt.pattern_driven = tok[LED_COUNT].toggled;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    driven_r   <= driven_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
